[sv/drive_to_point_controller_core_macros.svh]
// Assertion macros used by the drive-to-point controller core.
`ifndef DRIVE_TO_POINT_CONTROLLER_CORE_MACROS_SVH
`define DRIVE_TO_POINT_CONTROLLER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define DTP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtp: property violated");
`define DTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtp: property violated");
`else
`define DTP_ASSERT_IMP(lbl, ante, cons)
`define DTP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/dtp_pkg.sv]
// Package with constants, codes and the arctangent table of the drive-to-point controller.
package dtp_pkg;

    localparam int DEF_CORDIC_STEPS  = 14;
    localparam int DEF_POSITION_BITS = 13;

    localparam int TABLE_LEN      = 24;
    localparam int STEP_BITS      = 5;
    localparam int ZW             = 28;
    localparam int MUL_A_BITS     = 18;
    localparam int MUL_B_BITS     = 16;
    localparam int MUL_P_BITS     = MUL_A_BITS + MUL_B_BITS;
    localparam int SUM_BITS       = 17;
    localparam int ERR_BITS       = 17;
    localparam int HEADING_BITS   = 14;
    localparam int DRIVE_BITS     = 13;
    localparam int LIM_BITS       = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 10;

    localparam logic [MUL_B_BITS-1:0]      INV_GAIN_Q16 = 16'd39797;
    localparam logic signed [ZW-1:0]       Z_DEG180     = 28'sd11796480;
    localparam logic signed [ERR_BITS-1:0] ERR_DEG180   = 17'sd2880;
    localparam logic signed [ERR_BITS-1:0] ERR_DEG360   = 17'sd5760;
    localparam logic signed [ERR_BITS-1:0] TURN_LIMIT   = 17'sd640;
    localparam logic [6:0]                 SPEED_CAP    = 7'd100;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_ARRIVED = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_SPEED = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT   = 2'd2;

    localparam logic [6:0] RST_MAX_SPEED = 7'd50;
    localparam logic [7:0] RST_TOLERANCE = 8'd8;
    localparam logic [9:0] RST_TIMEOUT   = 10'd200;

    // Arctangent of 2^-i in 1/65536 degree, rounded.
    function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_BITS-1:0] i);
        logic signed [ZW-1:0] a;
        unique case (i)
            5'd0:    a = 28'sd2949120;
            5'd1:    a = 28'sd1740967;
            5'd2:    a = 28'sd919879;
            5'd3:    a = 28'sd466945;
            5'd4:    a = 28'sd234379;
            5'd5:    a = 28'sd117304;
            5'd6:    a = 28'sd58666;
            5'd7:    a = 28'sd29335;
            5'd8:    a = 28'sd14668;
            5'd9:    a = 28'sd7334;
            5'd10:   a = 28'sd3667;
            5'd11:   a = 28'sd1833;
            5'd12:   a = 28'sd917;
            5'd13:   a = 28'sd458;
            5'd14:   a = 28'sd229;
            5'd15:   a = 28'sd115;
            5'd16:   a = 28'sd57;
            5'd17:   a = 28'sd29;
            5'd18:   a = 28'sd14;
            5'd19:   a = 28'sd7;
            5'd20:   a = 28'sd4;
            5'd21:   a = 28'sd2;
            5'd22:   a = 28'sd1;
            default: a = 28'sd0;
        endcase
        return a;
    endfunction

endpackage

[sv/drive_to_point_controller_core.sv]
// Drive-to-point controller: arrival check, CORDIC distance and bearing, P drive and turn.
//
// Usage: one input word per 10 ms control tick on the in_valid/in_ready channel,
// one result word per input on the out_valid/out_ready channel. Configuration
// registers (max speed, arrival tolerance, tick budget) are written through
// cfg_write/cfg_index/cfg_data while the block is idle.
// Sequence: an accepted word moves to S_CHECK. A word outside a run or one that
// times out goes straight to the output. A word near the target takes the exact
// arrival check through S_SQX, S_SQY and S_SQT. A full tick runs S_VINIT, the
// CORDIC_STEPS rotations in S_ROT, the gain correction in S_GLO and S_GHI, then
// S_DIST and S_WRAP, which repeats for each heading wrap correction (at most 2);
// a zero vector skips the rotations. The CORDIC rotator is iterative and all
// products share the single 18x16 multiplier.
// The block works on one word at a time: in_ready is high only when no word
// is in work, so a new word is taken only after the last result has been taken.
// The result is held in output registers until out_ready; a stalled receiver
// holds the block and back-pressures the input channel.
// Reset: no run is active, the tick count is zero, the reported stop code is
// target reached, and the registers return to 50 percent, 8/16 inch and 200 ticks.
module drive_to_point_controller_core
    import dtp_pkg::*;
#(
    parameter int CORDIC_STEPS  = DEF_CORDIC_STEPS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            start_run,
    input  logic signed [POSITION_BITS-1:0] target_x,
    input  logic signed [POSITION_BITS-1:0] target_y,
    input  logic signed [POSITION_BITS-1:0] position_x,
    input  logic signed [POSITION_BITS-1:0] position_y,
    input  logic signed [HEADING_BITS-1:0]  robot_heading,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [DRIVE_BITS-1:0]    left_drive,
    output logic signed [DRIVE_BITS-1:0]    right_drive,
    output logic [1:0]                      run_status
);

`include "drive_to_point_controller_core_macros.svh"

    localparam int DW  = POSITION_BITS + 1;
    localparam int W   = POSITION_BITS + 12;
    localparam int FW  = W + 16;
    localparam int DSW = W - 8;
    localparam int D10 = DSW + 4;
    localparam int BW  = ZW - 12;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_CHECK = 12'b0000_0000_0010,
        S_SQX   = 12'b0000_0000_0100,
        S_SQY   = 12'b0000_0000_1000,
        S_SQT   = 12'b0000_0001_0000,
        S_VINIT = 12'b0000_0010_0000,
        S_ROT   = 12'b0000_0100_0000,
        S_GLO   = 12'b0000_1000_0000,
        S_GHI   = 12'b0001_0000_0000,
        S_DIST  = 12'b0010_0000_0000,
        S_WRAP  = 12'b0100_0000_0000,
        S_OUT   = 12'b1000_0000_0000
    } state_t;

    state_t                      state_reg, state_next;
    logic [6:0]                  max_speed_reg;
    logic [7:0]                  tol_reg;
    logic [9:0]                  timeout_reg;
    logic [9:0]                  tick_count_reg, tick_count_next;
    logic                        run_active_reg, run_active_next;
    logic [1:0]                  stop_code_reg, stop_code_next;
    logic [STEP_BITS-1:0]        step_reg, step_next;

    logic signed [DW-1:0]        dx_reg, dx_next;
    logic signed [DW-1:0]        dy_reg, dy_next;
    logic signed [HEADING_BITS-1:0] heading_reg, heading_next;
    logic signed [W-1:0]         x_reg, x_next;
    logic signed [W-1:0]         y_reg, y_next;
    logic signed [ZW-1:0]        z_reg, z_next;
    logic [SUM_BITS-1:0]         sum_reg, sum_next;
    logic [MUL_P_BITS-1:0]       prod_lo_reg, prod_lo_next;
    logic [W-1:0]                xg_reg, xg_next;
    logic [LIM_BITS-1:0]         drive_reg, drive_next;
    logic signed [ERR_BITS-1:0]  err_reg, err_next;
    logic signed [DRIVE_BITS-1:0] left_reg, left_next;
    logic signed [DRIVE_BITS-1:0] right_reg, right_next;
    logic [1:0]                  status_reg, status_next;

    logic [DW-1:0]               ax;
    logic [DW-1:0]               ay;
    logic                        near;
    logic [MUL_A_BITS-1:0]       mul_a;
    logic [MUL_B_BITS-1:0]       mul_b;
    logic [MUL_P_BITS-1:0]       mul_p;
    logic signed [W-1:0]         rx, ry;
    logic signed [ZW-1:0]        rz;
    logic signed [W-1:0]         x0, y0;
    logic [FW-1:0]               full;
    logic [W-1:0]                xr;
    logic [DSW-1:0]              dist_val;
    logic [D10-1:0]              d10;
    logic [6:0]                  ms_lim;
    logic [LIM_BITS-1:0]         lim;
    logic signed [ZW-1:0]        zr;
    logic signed [BW-1:0]        bear;
    logic signed [ERR_BITS-1:0]  t2;
    logic signed [ERR_BITS-1:0]  turn;
    logic signed [DRIVE_BITS-1:0] drive_s;
    logic signed [DRIVE_BITS-1:0] turn_s;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign run_status  = status_reg;

    assign ax   = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign ay   = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
    assign near = (ax < DW'(tol_reg)) && (ay < DW'(tol_reg));

    // The shared multiplier serves the arrival squares and the CORDIC gain correction.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQX:
            begin
                mul_a = MUL_A_BITS'(ax[7:0]);
                mul_b = MUL_B_BITS'(ax[7:0]);
            end
            S_SQY:
            begin
                mul_a = MUL_A_BITS'(ay[7:0]);
                mul_b = MUL_B_BITS'(ay[7:0]);
            end
            S_SQT:
            begin
                mul_a = MUL_A_BITS'(tol_reg);
                mul_b = MUL_B_BITS'(tol_reg);
            end
            S_GLO:
            begin
                mul_a = x_reg[MUL_A_BITS-1:0];
                mul_b = INV_GAIN_Q16;
            end
            S_GHI:
            begin
                mul_a = MUL_A_BITS'(x_reg[W-1:MUL_A_BITS]);
                mul_b = INV_GAIN_Q16;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = MUL_P_BITS'(mul_a) * MUL_P_BITS'(mul_b);

    dtp_rot_step #(
        .W (W)
    ) u_rot (
        .x    (x_reg),
        .y    (y_reg),
        .z    (z_reg),
        .step (step_reg),
        .nx   (rx),
        .ny   (ry),
        .nz   (rz)
    );

    assign x0     = W'(dx_reg) <<< 8;
    assign y0     = W'(dy_reg) <<< 8;
    assign full   = (FW'(mul_p) << MUL_A_BITS) + FW'(prod_lo_reg);
    assign xr     = xg_reg + W'(128);
    assign dist_val = xr[W-1:8];
    assign d10    = D10'({dist_val, 3'b000}) + D10'({dist_val, 1'b0});
    assign ms_lim = (max_speed_reg > SPEED_CAP) ? SPEED_CAP : max_speed_reg;
    assign lim    = {ms_lim, 4'b0000};
    assign zr     = z_reg + ZW'(2048);
    assign bear   = zr[ZW-1:12];
    assign t2     = err_reg <<< 1;
    assign turn   = (t2 > TURN_LIMIT) ? TURN_LIMIT : ((t2 < -TURN_LIMIT) ? -TURN_LIMIT : t2);
    assign drive_s = $signed({2'b00, drive_reg});
    assign turn_s  = DRIVE_BITS'(turn);

    always_comb
    begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        run_active_next = run_active_reg;
        stop_code_next  = stop_code_reg;
        step_next       = step_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        heading_next    = heading_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        sum_next        = sum_reg;
        prod_lo_next    = prod_lo_reg;
        xg_next         = xg_reg;
        drive_next      = drive_reg;
        err_next        = err_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        status_next     = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dx_next      = DW'(target_x) - DW'(position_x);
                    dy_next      = DW'(target_y) - DW'(position_y);
                    heading_next = robot_heading;
                    if (start_run)
                    begin
                        tick_count_next = '0;
                        run_active_next = 1'b1;
                    end
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                left_next  = '0;
                right_next = '0;
                if (!run_active_reg)
                begin
                    status_next = stop_code_reg;
                    state_next  = S_OUT;
                end
                else if (tick_count_reg >= timeout_reg)
                begin
                    run_active_next = 1'b0;
                    stop_code_next  = ST_TIMEOUT;
                    status_next     = ST_TIMEOUT;
                    state_next      = S_OUT;
                end
                else if (near)
                begin
                    state_next = S_SQX;
                end
                else
                begin
                    state_next = S_VINIT;
                end
            end
            S_SQX:
            begin
                sum_next   = SUM_BITS'(mul_p);
                state_next = S_SQY;
            end
            S_SQY:
            begin
                sum_next   = sum_reg + SUM_BITS'(mul_p);
                state_next = S_SQT;
            end
            S_SQT:
            begin
                if (MUL_P_BITS'(sum_reg) < mul_p)
                begin
                    run_active_next = 1'b0;
                    stop_code_next  = ST_ARRIVED;
                    status_next     = ST_ARRIVED;
                    state_next      = S_OUT;
                end
                else
                begin
                    state_next = S_VINIT;
                end
            end
            S_VINIT:
            begin
                step_next = '0;
                if (dx_reg < 0)
                begin
                    x_next = -x0;
                    y_next = -y0;
                    z_next = (dy_reg >= 0) ? Z_DEG180 : -Z_DEG180;
                end
                else
                begin
                    x_next = x0;
                    y_next = y0;
                    z_next = '0;
                end
                // A zero vector skips the rotations so distance and bearing come out zero.
                if ((dx_reg == 0) && (dy_reg == 0))
                begin
                    state_next = S_GLO;
                end
                else
                begin
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                x_next    = rx;
                y_next    = ry;
                z_next    = rz;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(CORDIC_STEPS - 1))
                begin
                    state_next = S_GLO;
                end
            end
            S_GLO:
            begin
                prod_lo_next = mul_p;
                state_next   = S_GHI;
            end
            S_GHI:
            begin
                xg_next    = full[FW-1:16];
                state_next = S_DIST;
            end
            S_DIST:
            begin
                drive_next = (d10 > D10'(lim)) ? lim : d10[LIM_BITS-1:0];
                err_next   = ERR_BITS'(bear) - ERR_BITS'(heading_reg);
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if (err_reg > ERR_DEG180)
                begin
                    err_next = err_reg - ERR_DEG360;
                end
                else if (err_reg <= -ERR_DEG180)
                begin
                    err_next = err_reg + ERR_DEG360;
                end
                else
                begin
                    left_next   = drive_s + turn_s;
                    right_next  = drive_s - turn_s;
                    status_next = ST_RUNNING;
                    if (tick_count_reg != '1)
                    begin
                        tick_count_next = tick_count_reg + 1'b1;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_count_reg <= '0;
            run_active_reg <= 1'b0;
            stop_code_reg  <= ST_ARRIVED;
            step_reg       <= '0;
            max_speed_reg  <= RST_MAX_SPEED;
            tol_reg        <= RST_TOLERANCE;
            timeout_reg    <= RST_TIMEOUT;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            run_active_reg <= run_active_next;
            stop_code_reg  <= stop_code_next;
            step_reg       <= step_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_MAX_SPEED: max_speed_reg <= cfg_data[6:0];
                    CFG_TOLERANCE: tol_reg       <= cfg_data[7:0];
                    CFG_TIMEOUT:   timeout_reg   <= cfg_data[9:0];
                    default:       max_speed_reg <= max_speed_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        heading_reg <= heading_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        sum_reg     <= sum_next;
        prod_lo_reg <= prod_lo_next;
        xg_reg      <= xg_next;
        drive_reg   <= drive_next;
        err_reg     <= err_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        status_reg  <= status_next;
    end

    // A stopped or idle tick never commands motion.
    `DTP_ASSERT_IMP(a_stop_zero_drive, out_valid && (run_status != ST_RUNNING), (left_drive == '0) && (right_drive == '0))
    // A running result only comes from a run that is still active.
    `DTP_ASSERT_IMP(a_running_active, out_valid && (run_status == ST_RUNNING), run_active_reg)
    // An accepted word keeps the block busy in the following cycle.
    `DTP_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready && !out_valid)
    // The rotation counter stays inside the configured number of steps.
    `DTP_ASSERT_IMP(a_step_bound, state_reg == S_ROT, step_reg < STEP_BITS'(CORDIC_STEPS))

endmodule

[sv/dtp_rot_step.sv]
// One vectoring CORDIC micro-rotation, reused by the controller for every step.
module dtp_rot_step
    import dtp_pkg::*;
#(
    parameter int W = DEF_POSITION_BITS + 12
)(
    input  logic signed [W-1:0]     x,
    input  logic signed [W-1:0]     y,
    input  logic signed [ZW-1:0]    z,
    input  logic [STEP_BITS-1:0]    step,
    output logic signed [W-1:0]     nx,
    output logic signed [W-1:0]     ny,
    output logic signed [ZW-1:0]    nz
);

    logic signed [W-1:0]  xs;
    logic signed [W-1:0]  ys;
    logic signed [ZW-1:0] ang;

    assign xs  = x >>> step;
    assign ys  = y >>> step;
    assign ang = atan_q16(step);

    always_comb
    begin
        if (y > 0)
        begin
            nx = x + ys;
            ny = y - xs;
            nz = z + ang;
        end
        else
        begin
            nx = x - ys;
            ny = y + xs;
            nz = z - ang;
        end
    end

endmodule
